[design/bgd_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bgd_pkg: shared types and constants of the button gesture detector
// Event codes, register map, configuration bundle and the event push
// bundle that runs from the gesture core to the event queue.
// ---------------------------------------------------------------------------
package bgd_pkg;

  // Default width of the internal time base, in bits (16 to 64)
  localparam int TIME_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int TS_WIDTH     = 32;
  localparam int MS_WIDTH     = 16;
  localparam int APB_DW       = 32;
  localparam int APB_AW       = 5;
  localparam int CLICK_WIDTH  = 2;
  localparam logic [CLICK_WIDTH-1:0] CLICK_MAX = 2'd2;

  // Event queue depth (power of two, room for two pushes and slack)
  localparam int EVQ_DEPTH = 4;

  // Register reset values
  localparam logic                ACTIVE_LOW_RST   = 1'b1;
  localparam logic [MS_WIDTH-1:0] DEBOUNCE_RST     = 16'd50;
  localparam logic [MS_WIDTH-1:0] LONG_PRESS_RST   = 16'd800;
  localparam logic [MS_WIDTH-1:0] REPEAT_RST       = 16'd200;
  localparam logic [MS_WIDTH-1:0] DBL_GAP_RST      = 16'd300;

  typedef enum logic [1:0] {
    EV_LONG   = 2'd0,
    EV_REPEAT = 2'd1,
    EV_SINGLE = 2'd2,
    EV_DOUBLE = 2'd3
  } bgd_event_e;

  typedef enum logic [2:0] {
    REG_ACTIVE_LOW = 3'd0,
    REG_DEBOUNCE   = 3'd1,
    REG_LONG_PRESS = 3'd2,
    REG_REPEAT     = 3'd3,
    REG_DBL_GAP    = 3'd4
  } bgd_reg_e;

  typedef struct packed {
    logic                active_low;
    logic [MS_WIDTH-1:0] debounce_time;
    logic [MS_WIDTH-1:0] long_press_time;
    logic [MS_WIDTH-1:0] repeat_period;
    logic [MS_WIDTH-1:0] click_gap;
  } bgd_cfg_t;

  // Events caused by one poll: num is 0, 1 or 2; code0 goes out first
  typedef struct packed {
    logic [1:0] num;
    bgd_event_e code0;
    bgd_event_e code1;
  } bgd_push_t;

endpackage

[design/bgd_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bgd_if: stream interfaces of the button gesture detector
// Poll channel (level and timestamp in) and event channel (events out),
// both valid/ready with a transfer on valid and ready high.
// ---------------------------------------------------------------------------
interface bgd_poll_if;
  logic                        valid;
  logic                        ready;
  logic                        raw_level;
  logic [bgd_pkg::TS_WIDTH-1:0] now_ms;

  modport source (output valid, output raw_level, output now_ms, input ready);
  modport sink   (input valid, input raw_level, input now_ms, output ready);
endinterface

interface bgd_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_code;
  logic       last_event;

  modport source (output valid, output event_code, output last_event, input ready);
  modport sink   (input valid, input event_code, input last_event, output ready);
endinterface

[design/bgd_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bgd_core: debounce and gesture state of the button gesture detector
// Updates the button state on each accepted poll and reports the events
// that the poll causes to the event queue in the same cycle.
// ---------------------------------------------------------------------------
module bgd_core #(
  parameter int TIME_WIDTH = bgd_pkg::TIME_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         raw_level_i,
  input  logic [bgd_pkg::TS_WIDTH-1:0] now_ms_i,
  input  bgd_pkg::bgd_cfg_t            cfg_i,
  output bgd_pkg::bgd_push_t           push_o
);

  logic                                pressed_q, pressed_d;
  logic                                long_fired_q, long_fired_d;
  logic [bgd_pkg::CLICK_WIDTH-1:0]     click_q, click_d;
  logic [TIME_WIDTH-1:0]               change_time_q, change_time_d;
  logic [TIME_WIDTH-1:0]               press_start_q, press_start_d;
  logic [TIME_WIDTH-1:0]               repeat_time_q, repeat_time_d;
  logic [TIME_WIDTH-1:0]               release_time_q, release_time_d;

  logic                  logical;
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] el_change, el_press, el_repeat, el_release;

  // Reduce the timestamp to the time base
  assign now_t   = TIME_WIDTH'(now_ms_i);
  assign logical = cfg_i.active_low ? ~raw_level_i : raw_level_i;

  // Debounce, then decide the events of this poll
  always_comb begin
    pressed_d      = pressed_q;
    long_fired_d   = long_fired_q;
    click_d        = click_q;
    change_time_d  = change_time_q;
    press_start_d  = press_start_q;
    repeat_time_d  = repeat_time_q;
    release_time_d = release_time_q;
    push_o.num     = 2'd0;
    push_o.code0   = bgd_pkg::EV_LONG;
    push_o.code1   = bgd_pkg::EV_REPEAT;

    el_change = now_t - change_time_q;

    if (accept_i && (logical != pressed_q) &&
        (el_change >= TIME_WIDTH'(cfg_i.debounce_time))) begin
      change_time_d = now_t;
      pressed_d     = logical;
      if (logical) begin
        press_start_d = now_t;
        repeat_time_d = now_t;
        long_fired_d  = 1'b0;
      end else if (!long_fired_q) begin
        if (click_q < bgd_pkg::CLICK_MAX) begin
          click_d = click_q + 1'b1;
        end
        release_time_d = now_t;
      end
    end

    el_press   = now_t - press_start_d;
    el_repeat  = now_t - repeat_time_q;
    el_release = now_t - release_time_d;

    if (accept_i) begin
      if (pressed_d) begin
        if (!long_fired_d) begin
          if (el_press >= TIME_WIDTH'(cfg_i.long_press_time)) begin
            long_fired_d  = 1'b1;
            click_d       = '0;
            repeat_time_d = now_t;
            push_o.num    = 2'd2;
            push_o.code0  = bgd_pkg::EV_LONG;
            push_o.code1  = bgd_pkg::EV_REPEAT;
          end
        end else if (el_repeat >= TIME_WIDTH'(cfg_i.repeat_period)) begin
          repeat_time_d = now_t;
          push_o.num    = 2'd1;
          push_o.code0  = bgd_pkg::EV_REPEAT;
        end
      end else if (click_d == 2'd1) begin
        if (el_release >= TIME_WIDTH'(cfg_i.click_gap)) begin
          click_d      = '0;
          push_o.num   = 2'd1;
          push_o.code0 = bgd_pkg::EV_SINGLE;
        end
      end else if (click_d >= bgd_pkg::CLICK_MAX) begin
        click_d      = '0;
        push_o.num   = 2'd1;
        push_o.code0 = bgd_pkg::EV_DOUBLE;
      end
    end
  end

  // Hold the button state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q      <= 1'b0;
      long_fired_q   <= 1'b0;
      click_q        <= '0;
      change_time_q  <= '0;
      press_start_q  <= '0;
      repeat_time_q  <= '0;
      release_time_q <= '0;
    end else begin
      pressed_q      <= pressed_d;
      long_fired_q   <= long_fired_d;
      click_q        <= click_d;
      change_time_q  <= change_time_d;
      press_start_q  <= press_start_d;
      repeat_time_q  <= repeat_time_d;
      release_time_q <= release_time_d;
    end
  end

endmodule

[design/bgd_evq.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bgd_evq: event queue of the button gesture detector
// Takes up to two events per cycle from the core and hands out one per
// transfer; signals room only while two free slots remain.
// ---------------------------------------------------------------------------
module bgd_evq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bgd_pkg::bgd_push_t push_i,
  output logic               room_o,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [1:0]         event_code_o,
  output logic               last_event_o
);

  localparam int DEPTH = bgd_pkg::EVQ_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  typedef struct packed {
    bgd_pkg::bgd_event_e code;
    logic                last;
  } evq_entry_t;

  evq_entry_t        mem_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [PW:0]       cnt_q, cnt_d;
  logic              pop;

  assign valid_o      = (cnt_q != '0);
  assign pop          = valid_o && ready_i;
  assign room_o       = (cnt_q <= (PW+1)'(DEPTH - 2));
  assign event_code_o = mem_q[rd_ptr_q].code;
  assign last_event_o = mem_q[rd_ptr_q].last;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q + PW'(push_i.num);
    rd_ptr_d = rd_ptr_q + PW'(pop);
    cnt_d    = cnt_q + (PW+1)'(push_i.num) - (PW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store pushed events; the last one of a poll carries the last mark
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q].code <= push_i.code0;
      mem_q[wr_ptr_q].last <= (push_i.num == 2'd1);
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_q + PW'(1)].code <= push_i.code1;
      mem_q[wr_ptr_q + PW'(1)].last <= 1'b1;
    end
  end

endmodule

[design/button_gesture_detector_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// button_gesture_detector_unit: debounced click and long-press detector
// Events of a poll go into the event queue and leave it after any events queued before.
// Throughput: one poll per cycle while the event queue holds room for two
// events; the event channel drains one event per cycle while ready is high, so
// the sustained poll rate is bounded by the number of events it produces.
// Reset: asynchronous, clears state and restores register defaults at once.
// ---------------------------------------------------------------------------
module button_gesture_detector_unit #(
  parameter int TIME_WIDTH = bgd_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bgd_poll_if.sink                      poll_i,
  bgd_event_if.source                   event_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bgd_pkg::APB_AW-1:0]    paddr,
  input  logic [bgd_pkg::APB_DW-1:0]    pwdata,
  output logic [bgd_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  bgd_pkg::bgd_cfg_t  cfg_q, cfg_d;
  bgd_pkg::bgd_push_t push;
  logic               room;
  logic               accept;
  logic               cfg_wr;
  bgd_pkg::bgd_reg_e  reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = bgd_pkg::bgd_reg_e'(paddr[bgd_pkg::APB_AW-1:2]);

  // Decode register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_sel)
        bgd_pkg::REG_ACTIVE_LOW: cfg_d.active_low      = pwdata[0];
        bgd_pkg::REG_DEBOUNCE:   cfg_d.debounce_time   = pwdata[bgd_pkg::MS_WIDTH-1:0];
        bgd_pkg::REG_LONG_PRESS: cfg_d.long_press_time = pwdata[bgd_pkg::MS_WIDTH-1:0];
        bgd_pkg::REG_REPEAT:     cfg_d.repeat_period   = pwdata[bgd_pkg::MS_WIDTH-1:0];
        bgd_pkg::REG_DBL_GAP:    cfg_d.click_gap       = pwdata[bgd_pkg::MS_WIDTH-1:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  // Read back registers
  always_comb begin
    unique case (reg_sel)
      bgd_pkg::REG_ACTIVE_LOW: prdata = bgd_pkg::APB_DW'(cfg_q.active_low);
      bgd_pkg::REG_DEBOUNCE:   prdata = bgd_pkg::APB_DW'(cfg_q.debounce_time);
      bgd_pkg::REG_LONG_PRESS: prdata = bgd_pkg::APB_DW'(cfg_q.long_press_time);
      bgd_pkg::REG_REPEAT:     prdata = bgd_pkg::APB_DW'(cfg_q.repeat_period);
      bgd_pkg::REG_DBL_GAP:    prdata = bgd_pkg::APB_DW'(cfg_q.click_gap);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_low      <= bgd_pkg::ACTIVE_LOW_RST;
      cfg_q.debounce_time   <= bgd_pkg::DEBOUNCE_RST;
      cfg_q.long_press_time <= bgd_pkg::LONG_PRESS_RST;
      cfg_q.repeat_period   <= bgd_pkg::REPEAT_RST;
      cfg_q.click_gap       <= bgd_pkg::DBL_GAP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Take a poll whenever the queue has room for its events
  assign poll_i.ready = room;
  assign accept       = poll_i.valid && room;

  bgd_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .raw_level_i (poll_i.raw_level),
    .now_ms_i    (poll_i.now_ms),
    .cfg_i       (cfg_q),
    .push_o      (push)
  );

  bgd_evq u_evq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .room_o       (room),
    .valid_o      (event_o.valid),
    .ready_i      (event_o.ready),
    .event_code_o (event_o.event_code),
    .last_event_o (event_o.last_event)
  );

  // A long press is never the last event of a poll, and only it is not
  a_long_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_o.valid |-> ((event_o.event_code == bgd_pkg::EV_LONG) != event_o.last_event))
    else $error("long press and last-event mark disagree");

  // A hold repeat directly follows every long press
  a_long_then_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (event_o.valid && event_o.ready && (event_o.event_code == bgd_pkg::EV_LONG))
    |=> (event_o.valid && (event_o.event_code == bgd_pkg::EV_REPEAT)))
    else $error("long press not followed by hold repeat");

  // No events are pushed without a poll being taken in the same cycle
  a_push_needs_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.num != 2'd0) |-> accept)
    else $error("events pushed without a poll transfer");

endmodule
